[rtl/core/tle_pkg.sv]
// Shared types and constants of the terminal line editor.
`timescale 1ns / 1ps
`default_nettype none

package tle_pkg;

    localparam int LINE_MAX_DEF = 32;
    localparam int QDEPTH       = 2;

    // result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_DROP = 2'd3;

    // terminal characters
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_THREE    = 8'h33;
    localparam logic [7:0] CH_UPPER_C  = 8'h43;
    localparam logic [7:0] CH_UPPER_D  = 8'h44;
    localparam logic [7:0] CH_UPPER_K  = 8'h4B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_LOWER_S  = 8'h73;
    localparam logic [7:0] CH_LOWER_U  = 8'h75;
    localparam logic [7:0] CH_TILDE    = 8'h7E;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_ESC,
        PH_CSI,
        PH_DEL
    } phase_t;

    typedef enum logic [1:0] {
        OP_TEXT,
        OP_LEFT,
        OP_RIGHT,
        OP_DEL
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LEFT,
        ACT_RIGHT,
        ACT_DEL,
        ACT_BS,
        ACT_INS,
        ACT_LINE,
        ACT_DROP
    } act_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SHL_RD,
        S_SHL_WR,
        S_SHR_RD,
        S_SHR_WR,
        S_INS_WR,
        S_ECHO_C,
        S_CSI,
        S_PRE,
        S_TAIL_RD,
        S_TAIL_EM,
        S_POST,
        S_NL,
        S_LINE_RD,
        S_LINE_EM,
        S_END,
        S_DROP
    } back_state_t;

endpackage

`default_nettype wire

[rtl/core/tle_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none

module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/tle_front.sv]
// Front end: tracks the escape phase and turns received bytes into commands.
`timescale 1ns / 1ps
`default_nettype none

module tle_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rx_valid,
    output logic               rx_ready,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          q_full,
    output logic               push,
    output tle_pkg::cmd_t      cmd
);
    import tle_pkg::*;

    phase_t phase_reg, phase_next;
    logic   acc;

    assign rx_ready = !q_full;
    assign acc      = rx_valid && rx_ready;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_TEXT:
            begin
                if (acc && rx_byte == CH_ESC)
                begin
                    phase_next = PH_ESC;
                end
            end
            PH_ESC:
            begin
                if (acc)
                begin
                    phase_next = (rx_byte == CH_LBRACKET) ? PH_CSI : PH_TEXT;
                end
            end
            PH_CSI:
            begin
                if (acc)
                begin
                    phase_next = (rx_byte == CH_THREE) ? PH_DEL : PH_TEXT;
                end
            end
            PH_DEL:
            begin
                if (acc)
                begin
                    phase_next = PH_TEXT;
                end
            end
            default: phase_next = PH_TEXT;
        endcase
    end

    always_comb
    begin
        push   = 1'b0;
        cmd.op = OP_TEXT;
        cmd.ch = rx_byte;
        unique case (phase_reg)
            PH_TEXT:
            begin
                push = acc && (rx_byte != CH_ESC);
            end
            PH_ESC:
            begin
                push = 1'b0;
            end
            PH_CSI:
            begin
                if (rx_byte == CH_UPPER_D)
                begin
                    push   = acc;
                    cmd.op = OP_LEFT;
                end
                else if (rx_byte == CH_UPPER_C)
                begin
                    push   = acc;
                    cmd.op = OP_RIGHT;
                end
            end
            PH_DEL:
            begin
                push   = acc && (rx_byte == CH_TILDE);
                cmd.op = OP_DEL;
            end
            default: push = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tle_queue.sv]
// Short command queue between the front end and the line engine.
`timescale 1ns / 1ps
`default_nettype none

module tle_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tle_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               full,
    output logic               valid,
    output tle_pkg::cmd_t      head
);
    import tle_pkg::*;

    localparam int PTRW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNTW = $clog2(QDEPTH + 1);

    cmd_t            slot_reg [QDEPTH];
    logic [PTRW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTRW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CNTW'(QDEPTH));
    assign valid   = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTRW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PTRW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTRW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PTRW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/tle_back.sv]
// Line engine: edits the line store and sequences echo, redraw, line, end and drop words.
`timescale 1ns / 1ps
`default_nettype none

module tle_back #(
    parameter int LINE_MAX = tle_pkg::LINE_MAX_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          echo_en,
    input  wire logic [7:0]    delim,
    input  wire logic          q_valid,
    input  wire tle_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               res_valid,
    input  wire logic          res_ready,
    output logic [1:0]         kind,
    output logic [7:0]         data,
    output logic               last
);
    import tle_pkg::*;

    localparam int PW = $clog2(LINE_MAX);
    localparam int CW = PW + 1;
    localparam logic [PW-1:0] LMAX_M1 = PW'(LINE_MAX - 1);

    back_state_t state_reg, state_next;
    act_t        act_reg, act_next, dec_act;
    logic [7:0]  ch_reg, ch_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [PW-1:0] len_reg, len_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [2:0]  cnt_reg, cnt_next;

    logic          ram_we;
    logic [PW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic          e_valid, e_last, emit_ok;
    logic [1:0]    e_kind;
    logic [7:0]    e_data;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    kind_reg;
    logic [7:0]    data_reg;
    logic          last_reg;

    logic [CW-1:0] idx_inc;
    logic          shl_more, shr_more, idx_below_len, printable;

    function automatic logic [7:0] pre_char(input logic [2:0] n);
        logic [7:0] c;
        unique case (n)
            3'd0, 3'd3: c = CH_ESC;
            3'd1, 3'd4: c = CH_LBRACKET;
            3'd2:       c = CH_LOWER_S;
            default:    c = CH_UPPER_K;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] post_char(input logic [2:0] n);
        logic [7:0] c;
        unique case (n)
            3'd0:    c = CH_SPACE;
            3'd1:    c = CH_ESC;
            3'd2:    c = CH_LBRACKET;
            default: c = CH_LOWER_U;
        endcase
        return c;
    endfunction

    tle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign emit_ok       = !out_valid_reg || res_ready;
    assign idx_inc       = {1'b0, idx_reg} + CW'(1);
    assign shl_more      = idx_inc < {1'b0, len_reg};
    assign shr_more      = idx_reg > cur_reg;
    assign idx_below_len = idx_reg < len_reg;
    assign printable     = (q_cmd.ch >= CH_SPACE) && (q_cmd.ch <= CH_TILDE);

    // classify the head command against the current line
    always_comb
    begin
        dec_act = ACT_NONE;
        unique case (q_cmd.op)
            OP_LEFT:
            begin
                if (cur_reg != '0)
                begin
                    dec_act = ACT_LEFT;
                end
            end
            OP_RIGHT:
            begin
                if (cur_reg < len_reg)
                begin
                    dec_act = ACT_RIGHT;
                end
            end
            OP_DEL:
            begin
                if (cur_reg < len_reg)
                begin
                    dec_act = ACT_DEL;
                end
            end
            OP_TEXT:
            begin
                priority if (q_cmd.ch == CH_BS && cur_reg != '0)
                begin
                    dec_act = ACT_BS;
                end
                else if (printable)
                begin
                    if (len_reg < LMAX_M1)
                    begin
                        dec_act = ACT_INS;
                    end
                    else if (q_cmd.ch == delim)
                    begin
                        dec_act = ACT_DROP;
                    end
                end
                else if (q_cmd.ch == delim)
                begin
                    dec_act = ACT_LINE;
                end
            end
            default: dec_act = ACT_NONE;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (dec_act)
                        ACT_LEFT, ACT_RIGHT: state_next = echo_en ? S_CSI : S_IDLE;
                        ACT_DEL, ACT_BS:     state_next = S_SHL_RD;
                        ACT_INS:             state_next = S_SHR_RD;
                        ACT_DROP:            state_next = S_DROP;
                        ACT_LINE:            state_next = echo_en ? S_NL : S_LINE_RD;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_SHL_RD:
            begin
                if (shl_more)
                begin
                    state_next = S_SHL_WR;
                end
                else if (!echo_en)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = (act_reg == ACT_BS) ? S_CSI : S_PRE;
                end
            end
            S_SHL_WR:  state_next = S_SHL_RD;
            S_SHR_RD:  state_next = shr_more ? S_SHR_WR : S_INS_WR;
            S_SHR_WR:  state_next = S_SHR_RD;
            S_INS_WR:  state_next = echo_en ? S_ECHO_C : S_IDLE;
            S_ECHO_C:
            begin
                if (emit_ok)
                begin
                    state_next = (cur_reg == len_reg) ? S_IDLE : S_PRE;
                end
            end
            S_CSI:
            begin
                if (emit_ok && cnt_reg == 3'd2)
                begin
                    state_next = (act_reg == ACT_BS) ? S_PRE : S_IDLE;
                end
            end
            S_PRE:
            begin
                if (emit_ok && cnt_reg == 3'd5)
                begin
                    state_next = S_TAIL_RD;
                end
            end
            S_TAIL_RD: state_next = idx_below_len ? S_TAIL_EM : S_POST;
            S_TAIL_EM:
            begin
                if (emit_ok)
                begin
                    state_next = S_TAIL_RD;
                end
            end
            S_POST:
            begin
                if (emit_ok && cnt_reg == 3'd3)
                begin
                    state_next = S_IDLE;
                end
            end
            S_NL:
            begin
                if (emit_ok && cnt_reg == 3'd1)
                begin
                    state_next = S_LINE_RD;
                end
            end
            S_LINE_RD: state_next = idx_below_len ? S_LINE_EM : S_END;
            S_LINE_EM:
            begin
                if (emit_ok)
                begin
                    state_next = S_LINE_RD;
                end
            end
            S_END, S_DROP:
            begin
                if (emit_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and emitted words
    always_comb
    begin
        act_next  = act_reg;
        ch_next   = ch_reg;
        idx_next  = idx_reg;
        len_next  = len_reg;
        cur_next  = cur_reg;
        cnt_next  = cnt_reg;
        q_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = ram_rdata;
        ram_raddr = idx_reg;
        e_valid   = 1'b0;
        e_kind    = KIND_ECHO;
        e_data    = 8'd0;
        e_last    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    act_next = dec_act;
                    ch_next  = q_cmd.ch;
                    cnt_next = 3'd0;
                    unique case (dec_act)
                        ACT_LEFT:  cur_next = cur_reg - PW'(1);
                        ACT_RIGHT: cur_next = cur_reg + PW'(1);
                        ACT_DEL:   idx_next = cur_reg;
                        ACT_BS:
                        begin
                            cur_next = cur_reg - PW'(1);
                            idx_next = cur_reg - PW'(1);
                        end
                        ACT_INS:   idx_next = len_reg;
                        ACT_LINE:  idx_next = '0;
                        default:   idx_next = idx_reg;
                    endcase
                end
            end
            S_SHL_RD:
            begin
                ram_raddr = idx_inc[PW-1:0];
                if (!shl_more)
                begin
                    len_next = len_reg - PW'(1);
                    cnt_next = 3'd0;
                end
            end
            S_SHL_WR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_inc[PW-1:0];
            end
            S_SHR_RD:
            begin
                ram_raddr = idx_reg - PW'(1);
            end
            S_SHR_WR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg - PW'(1);
            end
            S_INS_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = ch_reg;
                len_next  = len_reg + PW'(1);
                cur_next  = cur_reg + PW'(1);
            end
            S_ECHO_C:
            begin
                e_valid  = 1'b1;
                e_data   = ch_reg;
                e_last   = (cur_reg == len_reg);
                cnt_next = 3'd0;
            end
            S_CSI:
            begin
                e_valid = 1'b1;
                unique case (cnt_reg)
                    3'd0:    e_data = CH_ESC;
                    3'd1:    e_data = CH_LBRACKET;
                    default: e_data = (act_reg == ACT_RIGHT) ? CH_UPPER_C : CH_UPPER_D;
                endcase
                e_last = (cnt_reg == 3'd2) && (act_reg != ACT_BS);
                if (emit_ok)
                begin
                    cnt_next = (cnt_reg == 3'd2) ? 3'd0 : cnt_reg + 3'd1;
                end
            end
            S_PRE:
            begin
                e_valid = 1'b1;
                e_data  = pre_char(cnt_reg);
                if (emit_ok)
                begin
                    if (cnt_reg == 3'd5)
                    begin
                        cnt_next = 3'd0;
                        idx_next = cur_reg;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end
            S_TAIL_RD:
            begin
                ram_raddr = idx_reg;
            end
            S_TAIL_EM:
            begin
                e_valid = 1'b1;
                e_data  = ram_rdata;
                if (emit_ok)
                begin
                    idx_next = idx_inc[PW-1:0];
                end
            end
            S_POST:
            begin
                e_valid = 1'b1;
                e_data  = post_char(cnt_reg);
                e_last  = (cnt_reg == 3'd3);
                if (emit_ok)
                begin
                    cnt_next = (cnt_reg == 3'd3) ? 3'd0 : cnt_reg + 3'd1;
                end
            end
            S_NL:
            begin
                e_valid = 1'b1;
                e_data  = (cnt_reg == 3'd0) ? CH_CR : CH_LF;
                if (emit_ok)
                begin
                    cnt_next = (cnt_reg == 3'd1) ? 3'd0 : 3'd1;
                end
            end
            S_LINE_RD:
            begin
                ram_raddr = idx_reg;
            end
            S_LINE_EM:
            begin
                e_valid = 1'b1;
                e_kind  = KIND_LINE;
                e_data  = ram_rdata;
                if (emit_ok)
                begin
                    idx_next = idx_inc[PW-1:0];
                end
            end
            S_END:
            begin
                e_valid = 1'b1;
                e_kind  = KIND_END;
                e_data  = 8'(len_reg);
                e_last  = 1'b1;
                if (emit_ok)
                begin
                    len_next = '0;
                    cur_next = '0;
                end
            end
            S_DROP:
            begin
                e_valid = 1'b1;
                e_kind  = KIND_DROP;
                e_data  = 8'd0;
                e_last  = 1'b1;
                if (emit_ok)
                begin
                    len_next = '0;
                    cur_next = '0;
                end
            end
            default: e_valid = 1'b0;
        endcase
    end

    // output word register
    always_comb
    begin
        if (e_valid && emit_ok)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign last      = last_reg;

    always_ff @(posedge clk)
    begin
        ch_reg  <= ch_next;
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        if (e_valid && emit_ok)
        begin
            kind_reg <= e_kind;
            data_reg <= e_data;
            last_reg <= e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= ACT_NONE;
            len_reg       <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/terminal_line_editor.sv]
// Top level of the terminal line editor.
`timescale 1ns / 1ps
`default_nettype none

// Terminal line editor. Received bytes enter on rx and are taken one per
// cycle while the two-entry command queue has room; escape sequences
// (ESC [ D, ESC [ C, ESC [ 3 ~) are recognized on entry. The line engine
// then works one command at a time against a line RAM with one write
// port and a registered read: each byte moved by an insert or delete is
// read and then written, each redraw tail byte or completed line byte is
// read and then emitted, and each fixed echo byte is emitted directly;
// any word waits while res_ready is low. Results leave through a
// registered res port, kind/data/last, with last set on the final word
// that each command emits. cfg_index 0 is echo enable (bit 0, reset 1),
// index 1 the line delimiter (reset 10); write them only when the block
// is quiet. The line RAM needs no clearing after reset.
module terminal_line_editor #(
    parameter int LINE_MAX = tle_pkg::LINE_MAX_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_ready,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic [1:0]      kind,
    output logic [7:0]      data,
    output logic            last,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data
);
    import tle_pkg::*;

    localparam logic CFG_ECHO  = 1'b0;
    localparam logic CFG_DELIM = 1'b1;

    logic       echo_reg, echo_next;
    logic [7:0] delim_reg, delim_next;

    logic q_full, q_valid, q_push, q_pop;
    cmd_t push_cmd, head_cmd;

    always_comb
    begin
        echo_next  = echo_reg;
        delim_next = delim_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ECHO:  echo_next  = cfg_data[0];
                CFG_DELIM: delim_next = cfg_data;
                default:   echo_next  = echo_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_reg  <= 1'b1;
            delim_reg <= CH_LF;
        end
        else
        begin
            echo_reg  <= echo_next;
            delim_reg <= delim_next;
        end
    end

    tle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .push     (q_push),
        .cmd      (push_cmd)
    );

    tle_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    tle_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .echo_en   (echo_reg),
        .delim     (delim_reg),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .kind      (kind),
        .data      (data),
        .last      (last)
    );

endmodule

`default_nettype wire
